// ===== design/single_wire_sensor_frame_receiver_top_macros.svh =====
// Assertion helpers shared by the receiver modules.
// Both expect clock aclk and active-low reset aresetn in scope.
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_TOP_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication.
`define SWSFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/swsfr_pkg.sv =====
`timescale 1ns / 1ps
package swsfr_pkg;

    // Tick counter width, 8 to 24.
    localparam int TICK_BITS = 16;
    localparam int CMP_BITS  = (TICK_BITS > 16) ? TICK_BITS : 16;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    localparam int PHASE_BITS = 7;
    localparam logic [PHASE_BITS-1:0] PHASE_COUNT      = 7'd83;
    localparam logic [PHASE_BITS-1:0] FIRST_DATA_PHASE = 7'd4;
    localparam int FRAME_BITS = 40;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_LOW = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_THR   = 2'd2;

    localparam logic [15:0] START_LOW_RESET = 16'd18000;
    localparam logic [7:0]  TIMEOUT_RESET   = 8'd90;
    localparam logic [7:0]  ONE_THR_RESET   = 8'd30;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_RECV  = 2'd2
    } mode_t;

    typedef struct packed {
        logic is_start;
        logic line_level;
    } item_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  timeout_ticks;
        logic [7:0]  one_threshold_ticks;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        frame_done;
        logic [1:0]  status;
        logic [15:0] humidity_word;
        logic [15:0] temperature_word;
        logic [7:0]  humidity_integer;
        logic [7:0]  temperature_integer;
    } result_t;

endpackage

// ===== design/swsfr_front.sv =====
`timescale 1ns / 1ps
`include "single_wire_sensor_frame_receiver_top_macros.svh"
module swsfr_front
    import swsfr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  s_cmd,
    input  logic  s_line_level,
    input  logic  pop,
    output logic  q_valid,
    output item_t q_item
);

    // two-entry item queue towards the frame engine
    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      item_in;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        item_in.is_start   = s_cmd;
        item_in.line_level = s_line_level;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    `SWSFR_ASSERT_NOW(a_count_range, 1'b1, count_reg != 2'd3, "queue count out of range")
    `SWSFR_ASSERT_NOW(a_no_pop_empty, pop, count_reg != 2'd0, "pop from empty queue")
    `SWSFR_ASSERT_NEXT(a_push_counted, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "push not counted")

endmodule

// ===== design/swsfr_back.sv =====
`timescale 1ns / 1ps
`include "single_wire_sensor_frame_receiver_top_macros.svh"
module swsfr_back
    import swsfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    mode_t                  mode_reg, mode_next;
    logic [TICK_BITS-1:0]   ticks_reg, ticks_next;
    logic [PHASE_BITS-1:0]  index_reg, index_next;
    logic [FRAME_BITS-1:0]  bits_reg, bits_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg;
    result_t                res;

    logic                   run_recv;
    logic [TICK_BITS-1:0]   recv_ticks;
    logic [PHASE_BITS-1:0]  recv_index;
    logic [TICK_BITS-1:0]   ticks_inc;
    logic [PHASE_BITS-1:0]  index_inc;
    logic                   level;
    logic                   bit_val;
    logic [FRAME_BITS-1:0]  bits_shift;
    logic [7:0]             sum;

    assign pop      = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        mode_next  = mode_reg;
        ticks_next = ticks_reg;
        index_next = index_reg;
        bits_next  = bits_reg;
        res        = '0;
        run_recv   = 1'b0;
        recv_ticks = ticks_reg;
        recv_index = index_reg;

        unique case (mode_reg)
            MODE_START: begin
                if ((CMP_BITS'(ticks_reg) < CMP_BITS'(cfg.start_low_ticks)) &&
                    (ticks_reg != TICK_MAX)) begin
                    ticks_next    = ticks_reg + 1'b1;
                    res.drive_low = 1'b1;
                end else begin
                    // low pulse over: this tick already times the first phase
                    run_recv   = 1'b1;
                    recv_ticks = '0;
                    recv_index = '0;
                end
            end
            MODE_RECV: begin
                run_recv = 1'b1;
            end
            default: begin
                mode_next = MODE_IDLE;
                if (q_item.is_start) begin
                    bits_next  = '0;
                    index_next = '0;
                    ticks_next = '0;
                    if (cfg.start_low_ticks != 16'd0) begin
                        mode_next     = MODE_START;
                        ticks_next    = TICK_BITS'(1);
                        res.drive_low = 1'b1;
                    end else begin
                        mode_next = MODE_RECV;
                    end
                end
            end
        endcase

        // phase timing; even phases are high, odd low
        level      = ~recv_index[0];
        ticks_inc  = (recv_ticks == TICK_MAX) ? recv_ticks : recv_ticks + 1'b1;
        index_inc  = recv_index + 1'b1;
        bit_val    = (recv_ticks > TICK_BITS'(cfg.one_threshold_ticks));
        bits_shift = (recv_index >= FIRST_DATA_PHASE && !recv_index[0]) ?
                     {bits_reg[FRAME_BITS-2:0], bit_val} : bits_reg;
        sum        = bits_shift[39:32] + bits_shift[31:24] + bits_shift[23:16] +
                     bits_shift[15:8];

        if (run_recv) begin
            mode_next  = MODE_RECV;
            ticks_next = recv_ticks;
            index_next = recv_index;
            if (q_item.line_level == level) begin
                ticks_next = ticks_inc;
                if (ticks_inc > TICK_BITS'(cfg.timeout_ticks)) begin
                    res.frame_done = 1'b1;
                    res.status     = STATUS_TIMEOUT;
                    mode_next      = MODE_IDLE;
                    ticks_next     = '0;
                    index_next     = '0;
                end
            end else begin
                bits_next  = bits_shift;
                index_next = index_inc;
                ticks_next = TICK_BITS'(1);
                if (index_inc >= PHASE_COUNT) begin
                    res.frame_done          = 1'b1;
                    res.status              = (sum == bits_shift[7:0]) ? STATUS_OK
                                                                       : STATUS_CHECKSUM;
                    res.humidity_word       = bits_shift[39:24];
                    res.temperature_word    = bits_shift[23:8];
                    res.humidity_integer    = bits_shift[39:32];
                    res.temperature_integer = bits_shift[23:16];
                    mode_next               = MODE_IDLE;
                    ticks_next              = '0;
                    index_next              = '0;
                end
            end
        end

        out_valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            ticks_reg     <= '0;
            index_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                mode_reg  <= mode_next;
                ticks_reg <= ticks_next;
                index_reg <= index_next;
                bits_reg  <= bits_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= res;
        end
    end

    `SWSFR_ASSERT_NOW(a_no_pop_stalled, out_valid_reg && !m_ready, !pop,
        "item taken while result stalled")
    `SWSFR_ASSERT_NEXT(a_done_to_idle, pop && res.frame_done, mode_reg == MODE_IDLE,
        "engine not idle after frame end")
    `SWSFR_ASSERT_NEXT(a_drive_in_start, pop && res.drive_low, mode_reg == MODE_START,
        "line driven outside start pulse")
    `SWSFR_ASSERT_NOW(a_timeout_clear,
        out_valid_reg && out_reg.status == STATUS_TIMEOUT,
        out_reg.humidity_word == 16'd0 && out_reg.temperature_word == 16'd0,
        "timeout result carries data")

endmodule

// ===== design/single_wire_sensor_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// Single-wire humidity/temperature sensor frame receiver.
// Input channel (s_valid/s_ready): one item per microsecond tick, s_cmd = 0
// carries the sampled data line in s_line_level, s_cmd = 1 requests a read
// (taken as a plain tick while a read is running).
// Result channel (m_valid/m_ready): exactly one result per input item, in
// order. m_drive_low tells the pad to pull the line low; m_frame_done marks
// the item on which a frame finished, with m_status ok, checksum mismatch or
// phase timeout, and the received words and their high bytes.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 start pulse
// length, 1 phase timeout, 2 one-bit threshold, all in ticks; write while idle.
// Path: an accepted item is written into the input queue; the engine pops
// it when its output register is free and registers its result there.
// Throughput: one item per cycle while results are taken; the engine
// updates its state once per item.
// Reset (aresetn low, synchronous): engine idle, queue and output empty,
// registers back to 18000 / 90 / 30 ticks.
// Stalls: a held-off result stops the engine; the two-entry queue keeps
// taking items until full, then s_ready drops.
module single_wire_sensor_frame_receiver_top
    import swsfr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input ticks
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic                      s_line_level,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_drive_low,
    output logic                      m_frame_done,
    output logic [1:0]                m_status,
    output logic [15:0]               m_humidity_word,
    output logic [15:0]               m_temperature_word,
    output logic [7:0]                m_humidity_integer,
    output logic [7:0]                m_temperature_integer,
    // register writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    q_valid;
    item_t   q_item;
    logic    pop;
    result_t result;

    // Register file; unknown indexes are accepted and dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_LOW: cfg_next.start_low_ticks     = cfg_data;
                CFG_TIMEOUT:   cfg_next.timeout_ticks       = cfg_data[7:0];
                CFG_ONE_THR:   cfg_next.one_threshold_ticks = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks     <= START_LOW_RESET;
            cfg_reg.timeout_ticks       <= TIMEOUT_RESET;
            cfg_reg.one_threshold_ticks <= ONE_THR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accepts and tags items into a short queue.
    swsfr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_line_level (s_line_level),
        .pop          (pop),
        .q_valid      (q_valid),
        .q_item       (q_item)
    );

    // Back: frame engine with its output register.
    swsfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_drive_low           = result.drive_low;
    assign m_frame_done          = result.frame_done;
    assign m_status              = result.status;
    assign m_humidity_word       = result.humidity_word;
    assign m_temperature_word    = result.temperature_word;
    assign m_humidity_integer    = result.humidity_integer;
    assign m_temperature_integer = result.temperature_integer;

endmodule

// ===== tb/sv/sensor_rx_checker.sv =====
`timescale 1ns / 1ps
module sensor_rx_checker
    import swsfr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_cmd,
    input  logic                      s_line_level,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_drive_low,
    input  logic                      m_frame_done,
    input  logic [1:0]                m_status,
    input  logic [15:0]               m_humidity_word,
    input  logic [15:0]               m_temperature_word,
    input  logic [7:0]                m_humidity_integer,
    input  logic [7:0]                m_temperature_integer,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatch_count,
    output int                        outputs_pending
);

    localparam int REPORT_LIMIT = 10;

    // register copies
    logic [15:0]           start_low_reg;
    logic [7:0]            timeout_reg;
    logic [7:0]            one_thr_reg;

    // receiver state
    mode_t                 rx_mode;
    logic [TICK_BITS-1:0]  phase_ticks;
    logic [PHASE_BITS-1:0] phase_no;
    logic [FRAME_BITS-1:0] shift_bits;

    result_t               tick_outputs_due[$];

    initial begin
        mismatch_count  = 0;
        outputs_pending = 0;
    end

    function automatic string show(result_t r);
        return $sformatf("drv=%0b done=%0b st=%0d hum=%h tem=%h hi=%h ti=%h",
                         r.drive_low, r.frame_done, r.status, r.humidity_word,
                         r.temperature_word, r.humidity_integer, r.temperature_integer);
    endfunction

    task automatic close_read(input logic [1:0] st, inout result_t r);
        r.frame_done = 1'b1;
        r.status     = st;
        if (st != STATUS_TIMEOUT) begin
            r.humidity_word       = shift_bits[39:24];
            r.temperature_word    = shift_bits[23:8];
            r.humidity_integer    = shift_bits[39:32];
            r.temperature_integer = shift_bits[23:16];
        end
        rx_mode     = MODE_IDLE;
        phase_ticks = '0;
        phase_no    = '0;
    endtask

    // One tick of the receiver: returns what the block shows for this item.
    task automatic decode_tick(input logic cmd, input logic line, output result_t r);
        logic       run_phases;
        logic [7:0] byte_sum;
        r          = '0;
        run_phases = 1'b0;
        if (rx_mode != MODE_START && rx_mode != MODE_RECV) begin
            rx_mode = MODE_IDLE;
            if (cmd) begin
                shift_bits  = '0;
                phase_no    = '0;
                phase_ticks = '0;
                if (start_low_reg != 16'd0) begin
                    rx_mode     = MODE_START;
                    phase_ticks = 1;
                    r.drive_low = 1'b1;
                end else begin
                    rx_mode = MODE_RECV;
                end
            end
        end else if (rx_mode == MODE_START) begin
            if (phase_ticks < start_low_reg && phase_ticks != TICK_MAX) begin
                phase_ticks = phase_ticks + 1'b1;
                r.drive_low = 1'b1;
            end else begin
                // release tick is also the first line sample
                rx_mode     = MODE_RECV;
                phase_ticks = '0;
                phase_no    = '0;
                run_phases  = 1'b1;
            end
        end else begin
            run_phases = 1'b1;
        end

        if (run_phases) begin
            if (line == !phase_no[0]) begin
                if (phase_ticks != TICK_MAX)
                    phase_ticks = phase_ticks + 1'b1;
                if (phase_ticks > timeout_reg)
                    close_read(STATUS_TIMEOUT, r);
            end else begin
                if (phase_no >= FIRST_DATA_PHASE && !phase_no[0])
                    shift_bits = {shift_bits[FRAME_BITS-2:0], (phase_ticks > one_thr_reg)};
                phase_no    = phase_no + 1'b1;
                phase_ticks = 1;
                if (phase_no >= PHASE_COUNT) begin
                    byte_sum = shift_bits[39:32] + shift_bits[31:24] + shift_bits[23:16]
                             + shift_bits[15:8];
                    close_read((byte_sum == shift_bits[7:0]) ? STATUS_OK : STATUS_CHECKSUM, r);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        logic    bad;
        if (!aresetn) begin
            start_low_reg = START_LOW_RESET;
            timeout_reg   = TIMEOUT_RESET;
            one_thr_reg   = ONE_THR_RESET;
            rx_mode       = MODE_IDLE;
            phase_ticks   = '0;
            phase_no      = '0;
            shift_bits    = '0;
            tick_outputs_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.drive_low           = m_drive_low;
                got.frame_done          = m_frame_done;
                got.status              = m_status;
                got.humidity_word       = m_humidity_word;
                got.temperature_word    = m_temperature_word;
                got.humidity_integer    = m_humidity_integer;
                got.temperature_integer = m_temperature_integer;
                if (tick_outputs_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result %s", $realtime, show(got));
                end else begin
                    want = tick_outputs_due.pop_front();
                    bad  = (got.drive_low !== want.drive_low)
                        || (got.frame_done !== want.frame_done)
                        || (got.status !== want.status)
                        || (got.humidity_word !== want.humidity_word)
                        || (got.temperature_word !== want.temperature_word)
                        || (got.humidity_integer !== want.humidity_integer)
                        || (got.temperature_integer !== want.temperature_integer);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_tick(s_cmd, s_line_level, want);
                tick_outputs_due.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_LOW: start_low_reg = cfg_data;
                    CFG_TIMEOUT:   timeout_reg   = cfg_data[7:0];
                    CFG_ONE_THR:   one_thr_reg   = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        outputs_pending = tick_outputs_due.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import swsfr_pkg::*;

    localparam int CLK_HALF      = 4;          // ns, 8 ns period
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 400;
    localparam int MIN_ROUNDS    = 4;          // every idling mode at least once
    localparam int CYCLE_LIMIT   = 1_000_000;  // watchdog, far above the slowest run
    localparam int SETTLE_CYCLES = 8;          // pipeline is two deep, leave some margin
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;  // no register behind it

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // every block input starts at a known value
    logic                      s_valid      = 1'b0;
    logic                      s_cmd        = 1'b0;
    logic                      s_line_level = 1'b0;
    logic                      m_ready      = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = CFG_START_LOW;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    logic        s_ready;
    logic        m_valid;
    logic        m_drive_low;
    logic        m_frame_done;
    logic [1:0]  m_status;
    logic [15:0] m_humidity_word;
    logic [15:0] m_temperature_word;
    logic [7:0]  m_humidity_integer;
    logic [7:0]  m_temperature_integer;
    logic        cfg_ready;

    int mismatch_count;
    int outputs_pending;

    // idling of both channels, in percent of cycles
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // what the registers hold now, and the phase lengths that suit them
    int cur_start_low = START_LOW_RESET;
    int cur_timeout   = TIMEOUT_RESET;
    int cur_thr       = ONE_THR_RESET;
    int other_lo, other_hi, zero_lo, zero_hi, one_lo, one_hi;

    int items_sent  = 0;
    int cycle_count = 0;

    always #(CLK_HALF) aclk = ~aclk;

    single_wire_sensor_frame_receiver_top u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_cmd                 (s_cmd),
        .s_line_level          (s_line_level),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_drive_low           (m_drive_low),
        .m_frame_done          (m_frame_done),
        .m_status              (m_status),
        .m_humidity_word       (m_humidity_word),
        .m_temperature_word    (m_temperature_word),
        .m_humidity_integer    (m_humidity_integer),
        .m_temperature_integer (m_temperature_integer),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    sensor_rx_checker u_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_cmd                 (s_cmd),
        .s_line_level          (s_line_level),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_drive_low           (m_drive_low),
        .m_frame_done          (m_frame_done),
        .m_status              (m_status),
        .m_humidity_word       (m_humidity_word),
        .m_temperature_word    (m_temperature_word),
        .m_humidity_integer    (m_humidity_integer),
        .m_temperature_integer (m_temperature_integer),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .mismatch_count        (mismatch_count),
        .outputs_pending       (outputs_pending)
    );

    // Result side back-pressure, redrawn every cycle.
    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int pick(int lo, int hi);
        return $urandom_range(hi, lo);
    endfunction

    // Start requests sprinkled over a running read must be taken as plain ticks.
    function automatic logic busy_cmd();
        return ($urandom_range(0, 19) == 0);
    endfunction

    // 40 frame bits: humidity, temperature, then the byte-sum check byte
    // (deliberately spoilt when good is low).
    function automatic logic [39:0] pack_frame(logic [15:0] hum, logic [15:0] tem, logic good);
        logic [7:0] chk;
        chk = hum[15:8] + hum[7:0] + tem[15:8] + tem[7:0];
        if (!good)
            chk = chk ^ 8'($urandom_range(1, 255));
        return {hum, tem, chk};
    endfunction

    // One item on the input channel. Entered and left at a falling edge;
    // s_valid stays high on return so back-to-back items need no toggle.
    task automatic send_tick(input logic cmd, input logic line);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_line_level <= line;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outputs_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // New register set, written only once the block is idle and drained.
    // The upper byte of the 8-bit registers gets junk, which must be dropped.
    task automatic apply_timing(input int sl, input int to, input int thr);
        hold_until_drained();
        write_reg(CFG_START_LOW, 16'(sl));
        write_reg(CFG_TIMEOUT, {8'($urandom), 8'(to)});
        write_reg(CFG_ONE_THR, {8'($urandom), 8'(thr)});
        cur_start_low = sl;
        cur_timeout   = to;
        cur_thr       = thr;
        // short phases, bit lengths straddling the threshold, all within timeout
        other_lo = 1;
        other_hi = imax(1, imin(to, 3));
        zero_hi  = imax(1, imin(thr, to));
        zero_lo  = imax(1, zero_hi - 1);
        one_hi   = imax(1, imin(thr + 2, to));
        one_lo   = imax(1, imin(thr + 1, to));
    endtask

    // A full read as the sensor would answer it: start item, the low pulse,
    // three handshake phases, then 40 low/high pairs and the closing low tick.
    // abort_phase >= 0 stretches that phase one tick past the timeout.
    // lead >= 0 fixes the length of the first high phase (0 is allowed there).
    // drain_phase >= 0 pauses the sender there until all results are back.
    task automatic send_frame(input logic [39:0] bits, input int abort_phase,
                              input int lead, input int drain_phase);
        int   k;
        int   p;
        int   d;
        logic lvl;
        logic aborted;
        aborted = 1'b0;
        send_tick(1'b1, 1'($urandom));
        // line is not looked at while the block drives it low
        for (k = 1; k < cur_start_low; k++)
            send_tick(busy_cmd(), 1'($urandom));
        for (p = 0; p < int'(PHASE_COUNT) && !aborted; p++) begin
            if (p == drain_phase)
                hold_until_drained();
            lvl = (p % 2 == 0);
            if (p == abort_phase)
                d = cur_timeout + 1;
            else if (p == 0)
                d = (lead >= 0) ? lead : pick(0, other_hi);
            else if (lvl && p >= int'(FIRST_DATA_PHASE))
                d = bits[39 - (p - int'(FIRST_DATA_PHASE)) / 2] ? pick(one_lo, one_hi)
                                                                : pick(zero_lo, zero_hi);
            else
                d = pick(other_lo, other_hi);
            repeat (d) send_tick(busy_cmd(), lvl);
            aborted = (p == abort_phase);
        end
        if (!aborted)
            send_tick(busy_cmd(), 1'b0);
    endtask

    // Holding the line high runs any read into a timeout; harmless when idle.
    task automatic flush_line();
        repeat (cur_start_low + 2 * cur_timeout + 4) send_tick(1'b0, 1'b1);
    endtask

    initial begin : stimulus
        int         round;
        int         to;
        int         kind;
        int         random_stop;
        idle_mode_e idling;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part, no idling ----

        // idle ticks do nothing
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);

        // reset timeout, with a start pulse that needs the register's upper
        // byte; the first data high runs one tick past the timeout
        hold_until_drained();
        write_reg(CFG_START_LOW, 16'd257);
        cur_start_low = 257;
        other_lo = 1;
        other_hi = 3;
        zero_lo  = 29;
        zero_hi  = 30;
        one_lo   = 31;
        one_hi   = 32;
        send_frame(pack_frame(16'h2F81, 16'h00F3, 1'b1), int'(FIRST_DATA_PHASE), -1, -1);

        // no start pulse: timing begins on the item after the start
        apply_timing(0, 8, 3);
        // empty first high, bad check byte, sender drains mid-read
        send_frame(pack_frame(16'h0000, 16'h0000, 1'b0), -1, 0, 40);
        send_frame(pack_frame(16'($urandom), 16'($urandom), 1'b1), 0, -1, -1);
        // start, then a second start while busy counts as a high tick
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        flush_line();

        // zero timeout: any tick at the phase level aborts
        apply_timing(1, 0, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);

        // zero threshold: every high phase decodes as a one
        apply_timing(2, 2, 0);
        send_frame(pack_frame(16'($urandom), 16'($urandom), 1'b1), -1, -1, -1);

        // top threshold: nothing can decode as a one
        apply_timing(2, 2, 255);
        send_frame(pack_frame(16'($urandom), 16'($urandom), 1'b1), -1, -1, -1);

        // top timeout: a handshake low phase runs one tick past it
        apply_timing(3, 255, 254);
        send_frame(pack_frame(16'($urandom), 16'($urandom), 1'b1), 1, -1, -1);

        // writes to the unused index must leave the registers alone
        hold_until_drained();
        write_reg(CFG_SPARE, 16'($urandom));

        // ---- random part ----
        // Mostly well-formed reads with random data, some cut short by a
        // timeout, some plain noise. Register set and idling change per round.
        round       = 0;
        random_stop = items_sent + RANDOM_ITEMS;
        while (items_sent < random_stop || round < MIN_ROUNDS) begin
            idling = idle_mode_e'(round % 4);
            case (idling)
                IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin sender_idle_pct = 55; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 55; end
                default:       begin sender_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            to = pick(3, 8);
            apply_timing(pick(0, 6), to, pick(1, to - 1));
            kind = pick(0, 99);
            if (kind < 60) begin
                send_frame(pack_frame(16'($urandom), 16'($urandom), kind < 50), -1, -1,
                           ($urandom_range(0, 9) == 0) ? pick(1, 82) : -1);
            end else if (kind < 80) begin
                send_frame(pack_frame(16'($urandom), 16'($urandom), 1'b1),
                           pick(0, int'(PHASE_COUNT) - 1), -1, -1);
            end else begin
                repeat (pick(5, 40)) send_tick($urandom_range(0, 4) == 0, 1'($urandom));
                flush_line();
            end
            round++;
        end

        // ---- wind down ----
        hold_until_drained();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/swsfr_pkg.sv
design/swsfr_front.sv
design/swsfr_back.sv
design/single_wire_sensor_frame_receiver_top.sv
tb/sv/sensor_rx_checker.sv
tb/sv/tb_top.sv
